FILE: hw/rtl/lea_pkg.sv
package lea_pkg;

  // round-key store geometry: six key words per round, one bank per word slot
  localparam int KEY_STORE_WORDS = 192;
  localparam int KEYS_PER_ROUND  = 6;
  localparam int KEY_ROWS        = (KEY_STORE_WORDS + KEYS_PER_ROUND - 1) / KEYS_PER_ROUND;
  localparam int ROW_AW          = $clog2(KEY_ROWS);
  localparam int KSUM_W          = 9;

  // round counter and round-count register
  localparam int RND_W = 5;
  localparam int RC_W  = 6;
  localparam logic [RC_W-1:0]  RC_RESET = 6'd24;
  localparam logic [RC_W-1:0]  RC_MID   = 6'd24;
  localparam logic [RC_W-1:0]  RC_HIGH  = 6'd28;
  localparam logic [RND_W-1:0] LAST_24  = 5'd23;
  localparam logic [RND_W-1:0] LAST_28  = 5'd27;
  localparam logic [RND_W-1:0] LAST_32  = 5'd31;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ENC  = 2'd1,
    ACT_DEC  = 2'd2
  } action_t;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] block_t;
  typedef word_t [KEYS_PER_ROUND-1:0] key_row_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  key_index;
    word_t       key_word;
    word_t       block_word0;
    word_t       block_word1;
    word_t       block_word2;
    word_t       block_word3;
  } in_item_t;

  typedef struct packed {
    word_t result_word0;
    word_t result_word1;
    word_t result_word2;
    word_t result_word3;
  } out_item_t;

  // key store write request
  typedef struct packed {
    logic       en;
    logic [7:0] index;
    word_t      data;
  } key_wr_t;

  // index of the last round for a round-count register value
  function automatic logic [RND_W-1:0] last_round(input logic [RC_W-1:0] rc);
    logic [RND_W-1:0] res;
    if (rc > RC_HIGH) begin
      res = LAST_32;
    end else if (rc > RC_MID) begin
      res = LAST_28;
    end else begin
      res = LAST_24;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/lea_ram.sv
module lea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lea_keys.sv
module lea_keys (
  input  logic                    clk,
  input  lea_pkg::key_wr_t        wr,
  input  logic [lea_pkg::RND_W-1:0] rd_row,
  output lea_pkg::key_row_t       rd_keys
);

  // split the word index into row and bank: q = idx / 6 by reciprocal
  logic [15:0] prod;
  logic [5:0]  q;
  logic [7:0]  q6;
  logic [7:0]  rem_full;
  logic [2:0]  bank;
  logic        idx_ok;
  logic [lea_pkg::KSUM_W-1:0] row_base;

  assign prod     = 16'(wr.index) * 16'd171;
  assign q        = prod[15:10];
  assign q6       = {1'b0, q, 1'b0} + {q, 2'b0};
  assign rem_full = wr.index - q6;
  assign bank     = rem_full[2:0];
  assign idx_ok   = wr.index < 8'(lea_pkg::KEY_STORE_WORDS);
  assign row_base = lea_pkg::KSUM_W'(rd_row) * lea_pkg::KSUM_W'(lea_pkg::KEYS_PER_ROUND);

  for (genvar j = 0; j < lea_pkg::KEYS_PER_ROUND; j++) begin : g_bank
    logic          we;
    logic          ok;
    logic          ok_r;
    lea_pkg::word_t rdata;

    assign we = wr.en && idx_ok && (bank == 3'(j));
    // words past the end of the store read as zero
    assign ok = (row_base + lea_pkg::KSUM_W'(j)) <
                lea_pkg::KSUM_W'(lea_pkg::KEY_STORE_WORDS);

    lea_ram #(
      .WIDTH(32),
      .DEPTH(lea_pkg::KEY_ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(q[lea_pkg::ROW_AW-1:0]),
      .wdata(wr.data),
      .raddr(rd_row[lea_pkg::ROW_AW-1:0]),
      .rdata(rdata)
    );

    // mask travels with the registered read
    always_ff @(posedge clk) begin
      ok_r <= ok;
    end

    assign rd_keys[j] = ok_r ? rdata : '0;
  end

endmodule

FILE: hw/rtl/lea_round.sv
module lea_round (
  input  logic               dec,
  input  lea_pkg::block_t    x,
  input  lea_pkg::key_row_t  rk,
  output lea_pkg::block_t    y
);

  lea_pkg::word_t e0, e1, e2;
  lea_pkg::word_t p1, p2, p3;
  lea_pkg::word_t s0, s1, s2;

  // encrypt: three independent add-xor mixes
  assign s0 = (x[0] ^ rk[0]) + (x[1] ^ rk[1]);
  assign s1 = (x[1] ^ rk[2]) + (x[2] ^ rk[3]);
  assign s2 = (x[2] ^ rk[4]) + (x[3] ^ rk[5]);
  assign e0 = {s0[22:0], s0[31:23]};
  assign e1 = {s1[4:0],  s1[31:5]};
  assign e2 = {s2[2:0],  s2[31:3]};

  // decrypt: chained subtract-xor, each word needs the one before
  assign p1 = ({x[0][8:0],  x[0][31:9]}  - (x[3] ^ rk[0])) ^ rk[1];
  assign p2 = ({x[1][26:0], x[1][31:27]} - (p1   ^ rk[2])) ^ rk[3];
  assign p3 = ({x[2][28:0], x[2][31:29]} - (p2   ^ rk[4])) ^ rk[5];

  always_comb begin
    if (dec) begin
      y[0] = x[3];
      y[1] = p1;
      y[2] = p2;
      y[3] = p3;
    end else begin
      y[0] = e0;
      y[1] = e1;
      y[2] = e2;
      y[3] = x[0];
    end
  end

endmodule

FILE: hw/rtl/lea_block_cipher_unit.sv
// LEA-128 block cipher engine, one 128-bit block per transaction. Round keys
// are loaded one 32-bit word per transaction (action load, index 0..191, six
// words per round); the key schedule is done outside. An encrypt or decrypt
// transaction runs N = 24, 28 or 32 rounds as set by the round-count register
// (above 28 gives 32, above 24 gives 28, else 24); the next transaction is not
// taken before the result of the current one has moved to the output register,
// so back-to-back blocks are processed one at a time, not overlapped. The
// round unit computes one full round per cycle, fed by six key banks read in
// parallel one row per round; in_stall stays high while rounds run. The result
// sits in an output register, so a new transaction is taken while it waits on
// out_stall. Loads to an index above the store are dropped, action 3 is
// ignored, and round keys must be written before use. Write round_count only
// while the engine is idle.
module lea_block_cipher_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lea_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lea_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lea_pkg::RC_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [lea_pkg::RC_W-1:0]   rc_r;
  logic [lea_pkg::RND_W-1:0]  rnd_r, rnd_nxt;
  logic [lea_pkg::RND_W-1:0]  last_r, last_nxt;
  logic                       dec_r, dec_nxt;
  lea_pkg::block_t            x_r, x_nxt;
  lea_pkg::block_t            out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                       in_acc;
  logic                       cipher_acc;
  logic                       slot_free;
  logic                       last_step;
  logic                       in_dec;
  logic [lea_pkg::RND_W-1:0]  rd_row;
  lea_pkg::key_wr_t           key_wr;
  lea_pkg::key_row_t          rk;
  lea_pkg::block_t            y;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign in_dec     = (in_data.action == lea_pkg::ACT_DEC);
  assign cipher_acc = in_acc && ((in_data.action == lea_pkg::ACT_ENC) || in_dec);
  assign slot_free  = !out_valid_r || !out_stall;
  assign last_step  = dec_r ? (rnd_r == '0) : (rnd_r == last_r);
  assign cfg_ready  = 1'b1;

  // round-count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= lea_pkg::RC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rc_r <= cfg_data;
    end
  end

  // key load path
  always_comb begin
    key_wr.en    = in_acc && (in_data.action == lea_pkg::ACT_LOAD);
    key_wr.index = in_data.key_index;
    key_wr.data  = in_data.key_word;
  end

  // key row for the round that runs next cycle
  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_row = in_dec ? lea_pkg::last_round(rc_r) : '0;
      ST_RUN:  rd_row = dec_r ? rnd_r - lea_pkg::RND_W'(1) : rnd_r + lea_pkg::RND_W'(1);
      ST_HOLD: rd_row = '0;
      default: rd_row = '0;
    endcase
  end

  lea_keys u_keys (
    .clk    (clk),
    .wr     (key_wr),
    .rd_row (rd_row),
    .rd_keys(rk)
  );

  lea_round u_round (
    .dec(dec_r),
    .x  (x_r),
    .rk (rk),
    .y  (y)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    last_nxt      = last_r;
    dec_nxt       = dec_r;
    x_nxt         = x_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (cipher_acc) begin
          state_nxt = ST_RUN;
          dec_nxt   = in_dec;
          last_nxt  = lea_pkg::last_round(rc_r);
          rnd_nxt   = in_dec ? lea_pkg::last_round(rc_r) : '0;
          x_nxt[0]  = in_data.block_word0;
          x_nxt[1]  = in_data.block_word1;
          x_nxt[2]  = in_data.block_word2;
          x_nxt[3]  = in_data.block_word3;
        end
      end
      ST_RUN: begin
        x_nxt = y;
        if (last_step) begin
          if (slot_free) begin
            out_nxt       = y;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          rnd_nxt = dec_r ? rnd_r - lea_pkg::RND_W'(1) : rnd_r + lea_pkg::RND_W'(1);
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_nxt       = x_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rnd_r  <= rnd_nxt;
    last_r <= last_nxt;
    dec_r  <= dec_nxt;
    x_r    <= x_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_data.result_word0 = out_r[0];
  assign out_data.result_word1 = out_r[1];
  assign out_data.result_word2 = out_r[2];
  assign out_data.result_word3 = out_r[3];

  // round counter stays within the selected round range
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rnd_r <= last_r))
    else $error("round counter beyond last round");

  // last round index is one of the three key modes
  a_last_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |->
      (last_r == lea_pkg::LAST_24 || last_r == lea_pkg::LAST_28 ||
       last_r == lea_pkg::LAST_32))
    else $error("bad round count latched");

  // an accepted cipher transaction starts the rounds
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cipher_acc |=> (state_r == ST_RUN))
    else $error("cipher transaction did not start");

  // a finished block waits only behind a full output register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("result held while output register empty");

endmodule
